>>> src/contrast_seeking_colour_search_macros.svh
// assertion macros for the colour search checker
`ifndef CONTRAST_SEEKING_COLOUR_SEARCH_MACROS_SVH
`define CONTRAST_SEEKING_COLOUR_SEARCH_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define CSS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define CSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/css_pkg.sv
// shared types, constants and the linearization table for the colour search
`timescale 1ns / 1ps

package css_pkg;

   // sizes
   localparam int MEMO_ENTRIES = 8;
   localparam int SEARCH_STEPS = 50;
   localparam int MEMO_AW      = (MEMO_ENTRIES > 1) ? $clog2(MEMO_ENTRIES) : 1;
   localparam int SCAN_W       = $clog2(MEMO_ENTRIES + 1);
   localparam int STEP_W       = $clog2(SEARCH_STEPS + 1);

   localparam int COLOUR_W = 32;
   localparam int RATIO_W  = 13;
   localparam int LIN_W    = 17;
   localparam int LUM_W    = 17;
   localparam int ACC_W    = 33;

   // blend divide by 2*steps through a rounded-up reciprocal
   localparam int DIV_SH    = 27;
   localparam int DIV_D     = 2 * SEARCH_STEPS;
   localparam int DIV_RECIP = ((1 << DIV_SH) + DIV_D - 1) / DIV_D;
   localparam int V_W       = STEP_W + 8;
   localparam int X_W       = $clog2(511 * SEARCH_STEPS + 1);

   // shared multiplier
   localparam int MUL_A_W = 27;
   localparam int MUL_B_W = 21;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // luminance and ratio constants
   localparam logic [15:0] COEF_R = 16'd13933;
   localparam logic [15:0] COEF_G = 16'd46871;
   localparam logic [15:0] COEF_B = 16'd4732;
   localparam int RT_W = 21;
   localparam int DK_W = 22;
   localparam logic [ACC_W-1:0] LUM_ROUND  = ACC_W'(32768);
   localparam logic [RT_W-1:0]  GND_OFFSET = RT_W'(65536);
   localparam logic [DK_W-1:0]  DARK_LIMIT = DK_W'(294912);

   // byte lanes of an ARGB word
   localparam logic [1:0] CHAN_BLUE  = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_RED   = 2'd2;
   localparam logic [1:0] CHAN_ALPHA = 2'd3;

   typedef struct packed {
      logic                mode;
      logic [COLOUR_W-1:0] from_colour;
      logic [COLOUR_W-1:0] ground_colour;
      logic [RATIO_W-1:0]  min_ratio;
   } req_type;

   typedef struct packed {
      logic [COLOUR_W-1:0] result_colour;
      logic                memo_hit;
   } rsp_type;

   typedef struct packed {
      logic                en;
      logic [COLOUR_W-1:0] from_key;
      logic [COLOUR_W-1:0] ground_key;
      logic [RATIO_W-1:0]  ratio_key;
      logic [COLOUR_W-1:0] answer;
   } memo_wr_type;

   typedef struct packed {
      logic                valid;
      logic [COLOUR_W-1:0] from_key;
      logic [COLOUR_W-1:0] ground_key;
      logic [RATIO_W-1:0]  ratio_key;
      logic [COLOUR_W-1:0] answer;
   } memo_rd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LUM,
      ST_LUM_SUM,
      ST_BLEND_MUL,
      ST_BLEND_DIV,
      ST_BLEND_PUT,
      ST_RATIO_MUL,
      ST_RATIO_CMP
   } state_type;

   typedef logic [LIN_W-1:0] lin_table_type [256];

   // fifth power in q0.30 by repeated truncating products
   function automatic logic [63:0] pow5_q30(input logic [63:0] r);
      logic [63:0] p;
      p = r;
      for (int k = 0; k < 4; k++) begin
         p = (p * r) >> 30;
      end
      return p;
   endfunction

   // srgb to linear q1.16, evaluated at elaboration
   function automatic lin_table_type build_lin_table();
      lin_table_type tab;
      logic [63:0]   t;
      logic [63:0]   t2;
      logic [63:0]   lo;
      logic [63:0]   hi;
      logic [63:0]   mid;
      logic [63:0]   lin;
      for (int v = 0; v < 256; v++) begin
         if (v <= 10) begin
            tab[v] = LIN_W'((64'(v) * 64'd13107200 + 64'd329460) / 64'd658920);
         end else begin
            t  = (64'(1000 * v + 14025) << 30) / 64'd269025;
            t2 = (t * t) >> 30;
            lo = 64'd0;
            hi = 64'd1 << 30;
            // largest root whose fifth power stays at or below t2
            for (int n = 0; n < 32; n++) begin
               if (lo < hi) begin
                  mid = lo + ((hi - lo + 64'd1) >> 1);
                  if (pow5_q30(mid) <= t2) begin
                     lo = mid;
                  end else begin
                     hi = mid - 64'd1;
                  end
               end
            end
            lin = (((t2 * lo) >> 30) + 64'd8192) >> 14;
            if (lin > 64'd65536) begin
               lin = 64'd65536;
            end
            tab[v] = LIN_W'(lin);
         end
      end
      return tab;
   endfunction

   localparam lin_table_type LIN_TABLE = build_lin_table();

endpackage

>>> src/css_mul.sv
// shared multiplier with registered product
`timescale 1ns / 1ps

module css_mul
   import css_pkg::*;
(
   input  logic               clock,
   input  logic [MUL_A_W-1:0] mul_a,
   input  logic [MUL_B_W-1:0] mul_b,
   output logic [MUL_P_W-1:0] mul_p
);

   logic [MUL_P_W-1:0] product_ff;
   logic [MUL_P_W-1:0] product_in;

   // one product per cycle
   assign product_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign mul_p = product_ff;

endmodule

>>> src/css_memo.sv
// round-robin answer memo with registered read and per-entry valid bits
`timescale 1ns / 1ps

module css_memo
   import css_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [MEMO_AW-1:0] rd_addr,
   input  memo_wr_type        wr,
   output memo_rd_type        rd
);

   logic [COLOUR_W-1:0] from_mem   [MEMO_ENTRIES];
   logic [COLOUR_W-1:0] ground_mem [MEMO_ENTRIES];
   logic [RATIO_W-1:0]  ratio_mem  [MEMO_ENTRIES];
   logic [COLOUR_W-1:0] answer_mem [MEMO_ENTRIES];

   logic [MEMO_ENTRIES-1:0] valid_ff;
   logic [MEMO_AW-1:0]      ptr_ff;
   logic [MEMO_AW-1:0]      ptr_in;
   logic                    rd_valid_ff;
   logic [COLOUR_W-1:0]     rd_from_ff;
   logic [COLOUR_W-1:0]     rd_ground_ff;
   logic [RATIO_W-1:0]      rd_ratio_ff;
   logic [COLOUR_W-1:0]     rd_answer_ff;

   // replacement pointer wraps at the last entry
   assign ptr_in = (ptr_ff == MEMO_AW'(MEMO_ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;

   // valid bits, pointer and read valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         ptr_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         if (wr.en) begin
            valid_ff[ptr_ff] <= 1'b1;
            ptr_ff           <= ptr_in;
         end
      end
   end

   // key and answer storage
   always_ff @(posedge clock) begin
      if (wr.en) begin
         from_mem[ptr_ff]   <= wr.from_key;
         ground_mem[ptr_ff] <= wr.ground_key;
         ratio_mem[ptr_ff]  <= wr.ratio_key;
         answer_mem[ptr_ff] <= wr.answer;
      end
      rd_from_ff   <= from_mem[rd_addr];
      rd_ground_ff <= ground_mem[rd_addr];
      rd_ratio_ff  <= ratio_mem[rd_addr];
      rd_answer_ff <= answer_mem[rd_addr];
   end

   assign rd.valid      = rd_valid_ff;
   assign rd.from_key   = rd_from_ff;
   assign rd.ground_key = rd_ground_ff;
   assign rd.ratio_key  = rd_ratio_ff;
   assign rd.answer     = rd_answer_ff;

endmodule

>>> src/contrast_seeking_colour_search.sv
// colour search top level: sequencer around one shared multiplier and the memo
//
// A request word (mode, colour, ground, minimum ratio) is taken when start is
// high and busy is low. busy stays high until the answer is shown; the answer
// sits on rsp_data for one cycle with rsp_strobe high, and in that same cycle
// busy is low so the next request may already be taken. The receiver cannot
// hold the answer off.
// The memo is scanned one entry per cycle through its registered read port:
// a hit on any entry ends the scan and shows that entry's answer.
// On a miss the search runs on the one shared multiplier: the full memo
// scan, the ground luminance, then for each candidate tried 8 multiplies
// for the four blended channels, 3 luminance multiply-adds plus a sum, one
// ratio product and its compare. From 1 to SEARCH_STEPS + 1 candidates are
// tried; a miss also writes the answer into the memo. Only one request is in
// work at a time.
// Synchronous reset empties the memo, returns to idle and drops the strobe.
`timescale 1ns / 1ps

module contrast_seeking_colour_search
   import css_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   state_type           state_ff, state_in;
   logic [COLOUR_W-1:0] from_ff, from_in;
   logic [COLOUR_W-1:0] ground_ff, ground_in;
   logic [RATIO_W-1:0]  ratio_ff, ratio_in;
   logic [SCAN_W-1:0]   scan_ff, scan_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [1:0]          chan_ff, chan_in;
   logic [COLOUR_W-1:0] cand_ff, cand_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [LUM_W-1:0]    lg_ff, lg_in;
   logic [LUM_W-1:0]    lc_ff, lc_in;
   logic                dark_ff, dark_in;
   logic                lum_gnd_ff, lum_gnd_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [MUL_P_W-1:0]  mul_p;
   logic [MEMO_AW-1:0]  memo_rd_addr;
   memo_wr_type         memo_wr;
   memo_rd_type         memo_rd;

   logic [COLOUR_W-1:0] lum_src;
   logic [7:0]          lum_byte;
   logic [LIN_W-1:0]    lin_val;
   logic [15:0]         lum_coef;
   logic [7:0]          from_byte;
   logic [STEP_W-1:0]   steps_left;
   logic [V_W-1:0]      target_term;
   logic [V_W-1:0]      blend_v;
   logic [X_W-1:0]      blend_x;
   logic [7:0]          blend_q;
   logic [ACC_W-1:0]    lum_total;
   logic [LUM_W-1:0]    lum_now;
   logic [DK_W-1:0]     lum_x25;
   logic [LUM_W-1:0]    lum_hi;
   logic [LUM_W-1:0]    lum_lo;
   logic [RT_W-1:0]     rt_hi;
   logic [RT_W-1:0]     rt_lo;
   logic                ratio_pass;
   logic                memo_match;
   logic                last_step;

   css_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   css_memo u_memo (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (memo_rd_addr),
      .wr      (memo_wr),
      .rd      (memo_rd)
   );

   // luminance operand: ground or current candidate, one channel per cycle
   assign lum_src  = lum_gnd_ff ? ground_ff : cand_ff;
   assign lum_byte = lum_src[{chan_ff, 3'b000} +: 8];
   assign lin_val  = LIN_TABLE[lum_byte];

   always_comb begin
      unique case (chan_ff)
         CHAN_BLUE:  lum_coef = COEF_B;
         CHAN_GREEN: lum_coef = COEF_G;
         CHAN_RED:   lum_coef = COEF_R;
         default:    lum_coef = 16'd0;
      endcase
   end

   // blend: c*(S-i) from the multiplier, plus 255*i toward a white or opaque lane
   assign from_byte   = from_ff[{chan_ff, 3'b000} +: 8];
   assign steps_left  = STEP_W'(SEARCH_STEPS) - step_ff;
   assign target_term = ((chan_ff == CHAN_ALPHA) || !dark_ff)
                      ? ({step_ff, 8'h00} - V_W'(step_ff)) : '0;
   assign blend_v     = mul_p[V_W-1:0] + target_term;
   assign blend_x     = X_W'({blend_v, 1'b0}) + X_W'(SEARCH_STEPS);
   assign blend_q     = mul_p[DIV_SH +: 8];

   // luminance sum and dark-side test
   assign lum_total = acc_ff + mul_p[ACC_W-1:0];
   assign lum_now   = lum_total[16 +: LUM_W];
   assign lum_x25   = (DK_W'(lum_now) << 4) + (DK_W'(lum_now) << 3) + DK_W'(lum_now);

   // contrast test by cross multiplication
   assign lum_hi     = (lc_ff > lg_ff) ? lc_ff : lg_ff;
   assign lum_lo     = (lc_ff > lg_ff) ? lg_ff : lc_ff;
   assign rt_hi      = (RT_W'(lum_hi) << 4) + (RT_W'(lum_hi) << 2) + GND_OFFSET;
   assign rt_lo      = (RT_W'(lum_lo) << 4) + (RT_W'(lum_lo) << 2) + GND_OFFSET;
   assign ratio_pass = MUL_P_W'({rt_hi, 8'h00}) >= mul_p;
   assign last_step  = (step_ff == STEP_W'(SEARCH_STEPS));

   // memo compare on the entry read last cycle
   assign memo_match = memo_rd.valid
                    && (memo_rd.from_key == from_ff)
                    && (memo_rd.ground_key == ground_ff)
                    && (memo_rd.ratio_key == ratio_ff);
   assign memo_rd_addr = scan_ff[MEMO_AW-1:0];

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LUM: begin
            mul_a = MUL_A_W'(lum_coef);
            mul_b = MUL_B_W'(lin_val);
         end
         ST_BLEND_MUL: begin
            mul_a = MUL_A_W'(from_byte);
            mul_b = MUL_B_W'(steps_left);
         end
         ST_BLEND_DIV: begin
            mul_a = MUL_A_W'(DIV_RECIP);
            mul_b = MUL_B_W'(blend_x);
         end
         ST_RATIO_MUL: begin
            mul_a = MUL_A_W'(ratio_ff);
            mul_b = MUL_B_W'(rt_lo);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in      = state_ff;
      from_in       = from_ff;
      ground_in     = ground_ff;
      ratio_in      = ratio_ff;
      scan_in       = scan_ff;
      step_in       = step_ff;
      chan_in       = chan_ff;
      cand_in       = cand_ff;
      acc_in        = acc_ff;
      lg_in         = lg_ff;
      lc_in         = lc_ff;
      dark_in       = dark_ff;
      lum_gnd_in    = lum_gnd_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      memo_wr.en         = 1'b0;
      memo_wr.from_key   = from_ff;
      memo_wr.ground_key = ground_ff;
      memo_wr.ratio_key  = ratio_ff;
      memo_wr.answer     = cand_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               from_in   = req_data.from_colour;
               ground_in = req_data.mode ? req_data.from_colour : req_data.ground_colour;
               ratio_in  = req_data.min_ratio;
               scan_in   = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((scan_ff != '0) && memo_match) begin
               rsp_in.result_colour = memo_rd.answer;
               rsp_in.memo_hit      = 1'b1;
               rsp_strobe_in        = 1'b1;
               state_in             = ST_IDLE;
            end else if (scan_ff == SCAN_W'(MEMO_ENTRIES)) begin
               lum_gnd_in = 1'b1;
               chan_in    = CHAN_BLUE;
               state_in   = ST_LUM;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_LUM: begin
            acc_in = (chan_ff == CHAN_BLUE) ? LUM_ROUND : lum_total;
            if (chan_ff == CHAN_RED) begin
               state_in = ST_LUM_SUM;
            end else begin
               chan_in = chan_ff + 1'b1;
            end
         end
         ST_LUM_SUM: begin
            chan_in = CHAN_BLUE;
            if (lum_gnd_ff) begin
               lg_in    = lum_now;
               dark_in  = lum_x25 > DARK_LIMIT;
               step_in  = '0;
               state_in = ST_BLEND_MUL;
            end else begin
               lc_in    = lum_now;
               state_in = ST_RATIO_MUL;
            end
         end
         ST_BLEND_MUL: begin
            state_in = ST_BLEND_DIV;
         end
         ST_BLEND_DIV: begin
            state_in = ST_BLEND_PUT;
         end
         ST_BLEND_PUT: begin
            cand_in[{chan_ff, 3'b000} +: 8] = blend_q;
            if (chan_ff == CHAN_ALPHA) begin
               chan_in    = CHAN_BLUE;
               lum_gnd_in = 1'b0;
               state_in   = ST_LUM;
            end else begin
               chan_in  = chan_ff + 1'b1;
               state_in = ST_BLEND_MUL;
            end
         end
         ST_RATIO_MUL: begin
            state_in = ST_RATIO_CMP;
         end
         ST_RATIO_CMP: begin
            if (ratio_pass || last_step) begin
               rsp_in.result_colour = cand_ff;
               rsp_in.memo_hit      = 1'b0;
               rsp_strobe_in        = 1'b1;
               memo_wr.en           = 1'b1;
               state_in             = ST_IDLE;
            end else begin
               step_in  = step_ff + 1'b1;
               chan_in  = CHAN_BLUE;
               state_in = ST_BLEND_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      from_ff    <= from_in;
      ground_ff  <= ground_in;
      ratio_ff   <= ratio_in;
      scan_ff    <= scan_in;
      step_ff    <= step_in;
      chan_ff    <= chan_in;
      cand_ff    <= cand_in;
      acc_ff     <= acc_in;
      lg_ff      <= lg_in;
      lc_ff      <= lc_in;
      dark_ff    <= dark_in;
      lum_gnd_ff <= lum_gnd_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> src/css_check.sv
// port-level checker for the colour search, bound to the top level
`timescale 1ns / 1ps
`include "contrast_seeking_colour_search_macros.svh"

module css_check
   import css_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   // a taken request keeps the block busy in the next cycle
   `CSS_ASSERT_NEXT(a_take_busy, start && !busy, busy, "request taken but block not busy")

   // an answer is only shown once the block is free again
   `CSS_ASSERT_NOW(a_strobe_idle, rsp_strobe, !busy, "answer strobe while busy")

   // an answer strobe is never followed directly by another
   `CSS_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe, "answer strobe held two cycles")

   // busy only drops together with an answer
   `CSS_ASSERT_NOW(a_done_answer, $fell(busy), rsp_strobe, "busy dropped without an answer")

endmodule

bind contrast_seeking_colour_search css_check u_css_check (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);
